>>> design/rmts_pkg.sv
// Shared types and constants for the rate-monotonic tick scheduler.
// No dependencies; imported by every other design file.
package rmts_pkg;

  localparam int NUM_TASKS   = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_WIDTH  = 16;

  // Each time slot in a task register is at most 16 bits wide
  localparam int SLOT_W   = (TIME_WIDTH < 16) ? TIME_WIDTH : 16;
  localparam int ID_W     = $clog2(NUM_TASKS + 1);
  localparam int TASK_W   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int OCC_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int MASK_W   = (NUM_TASKS < 4) ? NUM_TASKS : 4;
  localparam int PARAM_REGS = (NUM_TASKS < 4) ? NUM_TASKS : 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int COUNT_W    = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TASK_PARAMS0 = 3'd1;

  // Bit offsets of the fields in a task register
  localparam int OFFSET_LSB = 0;
  localparam int WCET_LSB   = 16;
  localparam int PERIOD_LSB = 32;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] period;
    logic [SLOT_W-1:0] remain;
  } job_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_DEC
  } queue_op_t;

  typedef struct packed {
    queue_op_t op;
    job_t      job;
  } queue_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_RUN,
    S_DONE
  } sched_state_t;

endpackage

>>> design/rate_monotonic_tick_scheduler.sv
// Rate-monotonic tick scheduler: one result per start transaction.
// Tick 1: one queue insertion step per task, then one run step through the cell chain,
// then the result strobe; a new start is taken only back in idle, after the strobe.
// Tick 0: result strobe in the cycle after start, next start accepted in the cycle after the strobe.
// Synchronous reset clears the configuration, counters and queue occupancy.
// The receiver cannot stall: done is high for exactly one cycle per transaction.
module rate_monotonic_tick_scheduler
  import rmts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  tick,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic [31:0]           cycle_index,
  output logic [2:0]            running_task,
  output logic [3:0]            released_mask,
  output logic                  queue_overflow
);

  queue_cmd_t       cmd;
  logic [OCC_W-1:0] occupancy;
  job_t             job_bus [QUEUE_DEPTH];
  logic             gt_bus  [QUEUE_DEPTH];

  rmts_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .tick           (tick),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .head_job       (job_bus[0]),
    .busy           (busy),
    .done           (done),
    .cycle_index    (cycle_index),
    .running_task   (running_task),
    .released_mask  (released_mask),
    .queue_overflow (queue_overflow),
    .cmd            (cmd),
    .occupancy      (occupancy)
  );

  // Chain of queue cells, head at index zero
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic prev_gt;
    job_t prev_job;
    job_t next_job;

    if (i == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign prev_job = cmd.job;
    end else begin : g_mid
      assign prev_gt  = gt_bus[i-1];
      assign prev_job = job_bus[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_job = job_bus[i];
    end else begin : g_body
      assign next_job = job_bus[i+1];
    end

    rmts_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .head     (i == 0),
      .occupied (OCC_W'(i) < occupancy),
      .prev_gt  (prev_gt),
      .prev_job (prev_job),
      .next_job (next_job),
      .job      (job_bus[i]),
      .gt       (gt_bus[i])
    );
  end

endmodule

>>> design/rmts_cell.sv
// One slot of the period-sorted job queue.
// Depends on rmts_pkg; chained by the top level, each cell talking to its neighbours.
module rmts_cell
  import rmts_pkg::*;
(
  input  logic       clk,
  input  queue_cmd_t cmd,
  input  logic       head,
  input  logic       occupied,
  input  logic       prev_gt,
  input  job_t       prev_job,
  input  job_t       next_job,
  output job_t       job,
  output logic       gt
);

  // New job belongs at or before this slot: slot empty or strictly longer period
  assign gt = !occupied || (job.period > cmd.job.period);

  // Take the new job, shift right, shift left or decrement the head
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INSERT: begin
        if (prev_gt) begin
          job <= prev_job;
        end else if (gt) begin
          job <= cmd.job;
        end
      end
      OP_POP: begin
        job <= next_job;
      end
      OP_DEC: begin
        if (head) begin
          job.remain <= job.remain - SLOT_W'(1);
        end
      end
      default: begin
        job <= job;
      end
    endcase
  end

endmodule

>>> design/rmts_ctrl.sv
// Tick sequencer: configuration registers, phase counters, release checks and results.
// Depends on rmts_pkg; drives the cell chain of the job queue through queue_cmd_t.
module rmts_ctrl
  import rmts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  tick,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  job_t                  head_job,
  output logic                  busy,
  output logic                  done,
  output logic [31:0]           cycle_index,
  output logic [2:0]            running_task,
  output logic [3:0]            released_mask,
  output logic                  queue_overflow,
  output queue_cmd_t            cmd,
  output logic [OCC_W-1:0]      occupancy
);

  sched_state_t state, state_next;

  logic [COUNT_W-1:0]    task_count;
  logic [CFG_DATA_W-1:0] task_params [NUM_TASKS];
  logic [SLOT_W-1:0]     phase [NUM_TASKS];
  logic [31:0]           cycle_counter;
  logic [TASK_W-1:0]     task_idx;
  logic [NUM_TASKS-1:0]  released;
  logic [ID_W-1:0]       running;
  logic                  overflow;

  logic [NUM_TASKS-1:0]  release_hit;
  logic [SLOT_W-1:0]     cur_wcet;
  logic [SLOT_W-1:0]     cur_period;
  logic                  cur_release;
  logic                  last_task;
  logic                  queue_full;
  logic                  head_done;
  logic                  accept;

  assign accept     = start && (state == S_IDLE);
  assign cur_wcet   = task_params[task_idx][WCET_LSB +: SLOT_W];
  assign cur_period = task_params[task_idx][PERIOD_LSB +: SLOT_W];
  assign cur_release = release_hit[task_idx];
  assign last_task  = (task_idx == TASK_W'(NUM_TASKS - 1));
  assign queue_full = (occupancy == OCC_W'(QUEUE_DEPTH));
  assign head_done  = (head_job.remain == SLOT_W'(1));

  // Release test of every task against its wake offset
  always_comb begin
    for (int t = 0; t < NUM_TASKS; t++) begin
      release_hit[t] = (t < ((32'(task_count) > NUM_TASKS) ? NUM_TASKS : 32'(task_count)))
        && (task_params[t][PERIOD_LSB +: SLOT_W] != '0)
        && (phase[t] == task_params[t][OFFSET_LSB +: SLOT_W]);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = tick ? S_INSERT : S_DONE;
        end
      end
      S_INSERT: begin
        if (last_task) begin
          state_next = S_RUN;
        end
      end
      S_RUN:   state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs and queue command
  always_comb begin
    busy    = (state != S_IDLE);
    done    = (state == S_DONE);
    cmd.op  = OP_HOLD;
    cmd.job = '{id: ID_W'(task_idx) + ID_W'(1), period: cur_period, remain: cur_wcet};
    case (state)
      S_INSERT: begin
        if (cur_release && (cur_wcet != '0) && !queue_full) begin
          cmd.op = OP_INSERT;
        end
      end
      S_RUN: begin
        if (occupancy != '0) begin
          cmd.op = head_done ? OP_POP : OP_DEC;
        end
      end
      default: begin
        cmd.op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
      for (int t = 0; t < NUM_TASKS; t++) begin
        task_params[t] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_TASK_COUNT) begin
        task_count <= cfg_data[COUNT_W-1:0];
      end
      for (int t = 0; t < PARAM_REGS; t++) begin
        if (cfg_index == (REG_TASK_PARAMS0 + CFG_IDX_W'(t))) begin
          task_params[t] <= cfg_data;
        end
      end
    end
  end

  // Tick counters, occupancy and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_counter <= '0;
      occupancy     <= '0;
      task_idx      <= '0;
      for (int t = 0; t < NUM_TASKS; t++) begin
        phase[t] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          task_idx <= '0;
          if (accept) begin
            cycle_index <= cycle_counter;
            released    <= '0;
            overflow    <= 1'b0;
            running     <= '0;
          end
        end
        S_INSERT: begin
          task_idx <= task_idx + TASK_W'(1);
          if (cur_release) begin
            released[task_idx] <= 1'b1;
            if (cur_wcet != '0) begin
              if (queue_full) begin
                overflow <= 1'b1;
              end else begin
                occupancy <= occupancy + OCC_W'(1);
              end
            end
          end
        end
        S_RUN: begin
          // Run the head for one unit, drop it when finished
          if (occupancy != '0) begin
            running <= head_job.id;
            if (head_done) begin
              occupancy <= occupancy - OCC_W'(1);
            end
          end
          // Advance every phase counter, wrapping at the period
          for (int t = 0; t < NUM_TASKS; t++) begin
            if ((task_params[t][PERIOD_LSB +: SLOT_W] == '0) ||
                (({1'b0, phase[t]} + (SLOT_W+1)'(1)) >=
                 {1'b0, task_params[t][PERIOD_LSB +: SLOT_W]})) begin
              phase[t] <= '0;
            end else begin
              phase[t] <= phase[t] + SLOT_W'(1);
            end
          end
          cycle_counter <= cycle_counter + 32'd1;
        end
        default: begin
          task_idx <= '0;
        end
      endcase
    end
  end

  assign running_task   = 3'(running);
  assign released_mask  = 4'(released[MASK_W-1:0]);
  assign queue_overflow = overflow;

endmodule
